[hw/rtl/fpg_pkg.sv]
// Shared types, constants and lookup tables for the fuzzy P/D gain scheduler.
// Holds the breakpoint, rule and centre tables and the band search function.
// No dependencies.
`default_nettype none

package fpg_pkg;

    // Label count that takes part in defuzzification (range 2..7)
    localparam int LEVELS  = 7;
    // Size of every breakpoint, rule and centre table
    localparam int TBL_N   = 7;

    localparam int IN_W    = 16;
    localparam int MAG_W   = 15;
    localparam int X_W     = MAG_W + 4;      // magnitude times ten
    localparam int BP_W    = 9;              // breakpoints in tenths
    localparam int BAND_W  = 3;
    localparam int LAB_W   = 3;
    localparam int W_W     = 7;              // band weights and band widths
    localparam int PROD_W  = 2 * W_W;        // corner weight product
    localparam int DEN_W   = 2 * W_W;        // error width times rate width
    localparam int CEN_W   = 8;              // centre values
    localparam int TERM_W  = PROD_W + CEN_W;
    localparam int SUM_W   = TERM_W + 2;     // sum of four corner terms
    localparam int SCL_W   = 7;              // centre scale factors
    localparam int DSC_W   = DEN_W + SCL_W;  // scaled denominator
    localparam int DIV_W   = DSC_W + 1;      // doubled denominator
    localparam int NUM_W   = 32;             // rounding numerator
    localparam int Q_W     = 16;             // quotient, Q4.12
    localparam int FRAC_SH = 13;             // 2 * 4096
    localparam int N_LANE  = 2;
    localparam int LANE_P  = 0;
    localparam int LANE_D  = 1;
    localparam int P_SCALE = 100;
    localparam int D_SCALE = 10;

    typedef logic [BP_W-1:0]  t_bp  [TBL_N];
    typedef logic [LAB_W-1:0] t_rule [TBL_N][TBL_N];
    typedef logic [CEN_W-1:0] t_cen [TBL_N];

    localparam t_bp ERR_BP  = '{9'd0, 9'd45, 9'd90, 9'd135, 9'd170, 9'd235, 9'd270};
    localparam t_bp RATE_BP = '{9'd0, 9'd47, 9'd58, 9'd44, 9'd51, 9'd65, 9'd85};

    localparam t_rule KP_RULES = '{
        '{3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
        '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1},
        '{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
        '{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1},
        '{3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
        '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3}
    };

    localparam t_rule KD_RULES = '{
        '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6},
        '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5},
        '{3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5},
        '{3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
        '{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
        '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}
    };

    // P centres in hundredths, D centres in tenths
    localparam t_cen P_CENTRE = '{8'd91, 8'd98, 8'd100, 8'd114, 8'd122, 8'd128, 8'd135};
    localparam t_cen D_CENTRE = '{8'd35, 8'd45, 8'd50, 8'd65, 8'd70, 8'd75, 8'd95};

    typedef struct packed {
        logic signed [IN_W-1:0] error_value;
        logic signed [IN_W-1:0] error_rate_value;
    } t_in;

    typedef struct packed {
        logic [Q_W-1:0] gain_p;
        logic [Q_W-1:0] gain_d;
    } t_out;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [W_W-1:0]    num;
        logic [W_W-1:0]    den;
    } t_band;

    // Bands and corner weights of one request
    typedef struct packed {
        logic [BAND_W-1:0] eb;
        logic [BAND_W-1:0] rb;
        logic [W_W-1:0]    we0;
        logic [W_W-1:0]    we1;
        logic [W_W-1:0]    wr0;
        logic [W_W-1:0]    wr1;
        logic [W_W-1:0]    de;
        logic [W_W-1:0]    dr;
    } t_band_req;

    // Rounding numerators and doubled denominators, one lane per gain
    typedef struct packed {
        logic [N_LANE-1:0][NUM_W-1:0] num;
        logic [N_LANE-1:0][DIV_W-1:0] dv;
    } t_div_req;

    // Magnitude of a 16-bit signed value, saturating at the positive limit
    function automatic logic [MAG_W-1:0] mag_sat(input logic [IN_W-1:0] v);
        logic [IN_W-1:0] neg;
        neg = ~v + IN_W'(1);
        if (!v[IN_W-1]) begin
            mag_sat = v[MAG_W-1:0];
        end else if (neg[IN_W-1]) begin
            mag_sat = '1;
        end else begin
            mag_sat = neg[MAG_W-1:0];
        end
    endfunction

    // Comparisons run in table order, so a non-monotonic table skips bands
    function automatic t_band find_band(input t_bp bp, input logic [MAG_W-1:0] mag);
        t_band          b;
        logic [X_W-1:0] x10;
        logic           hit;
        int             d;
        x10    = X_W'(mag) * X_W'(10);
        b.band = BAND_W'(TBL_N - 1);
        b.num  = W_W'(1);
        b.den  = W_W'(1);
        hit    = 1'b0;
        d      = 0;
        if (x10 < X_W'(bp[0])) begin
            b.band = '0;
            hit    = 1'b1;
        end
        for (int k = 1; k < TBL_N; k++) begin
            if (!hit && x10 < X_W'(bp[k])) begin
                hit    = 1'b1;
                b.band = BAND_W'(k - 1);
                d      = int'(bp[k]) - int'(bp[k-1]);
                if (d > 0) begin
                    b.num = W_W'(X_W'(bp[k]) - x10);
                    b.den = W_W'(d);
                end
            end
        end
        return b;
    endfunction

    // Out-of-table indexes read label 0; such corners are always dropped
    function automatic logic [LAB_W-1:0] rule_p(input logic [BAND_W-1:0] row,
                                                input logic [BAND_W-1:0] col);
        rule_p = '0;
        if (int'(row) < TBL_N && int'(col) < TBL_N) begin
            rule_p = KP_RULES[row][col];
        end
    endfunction

    function automatic logic [LAB_W-1:0] rule_d(input logic [BAND_W-1:0] row,
                                                input logic [BAND_W-1:0] col);
        rule_d = '0;
        if (int'(row) < TBL_N && int'(col) < TBL_N) begin
            rule_d = KD_RULES[row][col];
        end
    endfunction

    function automatic logic [CEN_W-1:0] centre_p(input logic [LAB_W-1:0] lab);
        centre_p = '0;
        if (int'(lab) < TBL_N) begin
            centre_p = P_CENTRE[lab];
        end
    endfunction

    function automatic logic [CEN_W-1:0] centre_d(input logic [LAB_W-1:0] lab);
        centre_d = '0;
        if (int'(lab) < TBL_N) begin
            centre_d = D_CENTRE[lab];
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fpg_front.sv]
// Front end: input magnitudes, then band and membership weight per axis.
// Two register stages; uses fpg_pkg.
`default_nettype none

module fpg_front import fpg_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in       i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_band_req      o_out_data
);

    logic             r_v_a;
    logic [MAG_W-1:0] r_mag_e;
    logic [MAG_W-1:0] r_mag_r;
    logic             r_v_b;
    t_band_req        r_b;

    logic             ld_a;
    logic             ld_b;
    t_band            band_e;
    t_band            band_r;
    t_band_req        n_b;

    assign ld_b       = !r_v_b || i_out_ready;
    assign ld_a       = !r_v_a || ld_b;
    assign o_in_ready = ld_a;

    always_comb begin
        band_e  = find_band(ERR_BP, r_mag_e);
        band_r  = find_band(RATE_BP, r_mag_r);
        n_b.eb  = band_e.band;
        n_b.rb  = band_r.band;
        n_b.we0 = band_e.num;
        n_b.we1 = band_e.den - band_e.num;
        n_b.wr0 = band_r.num;
        n_b.wr1 = band_r.den - band_r.num;
        n_b.de  = band_e.den;
        n_b.dr  = band_r.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else begin
            if (ld_a) r_v_a <= i_in_valid;
            if (ld_b) r_v_b <= r_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a && i_in_valid) begin
            r_mag_e <= mag_sat(i_in_data.error_value);
            r_mag_r <= mag_sat(i_in_data.error_rate_value);
        end
        if (ld_b && r_v_a) begin
            r_b <= n_b;
        end
    end

    assign o_out_valid = r_v_b;
    assign o_out_data  = r_b;

endmodule

`default_nettype wire

[hw/rtl/fpg_rules.sv]
// Rule evaluation: corner weights, rule labels, centre-weighted sums and the
// rounding numerator and denominator per gain. Three stages; uses fpg_pkg.
`default_nettype none

module fpg_rules import fpg_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_band_req i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_div_req       o_out_data
);

    localparam int N_CRN = 4;

    // stage C: corner products, labels, enables
    logic                          r_v_c;
    logic [N_CRN-1:0][PROD_W-1:0]  r_prod;
    logic [N_CRN-1:0][LAB_W-1:0]   r_lab_p;
    logic [N_CRN-1:0][LAB_W-1:0]   r_lab_d;
    logic [N_CRN-1:0]              r_use;
    logic [DEN_W-1:0]              r_den;
    // stage D: centre-weighted terms, scaled denominators
    logic                          r_v_d;
    logic [N_CRN-1:0][TERM_W-1:0]  r_term_p;
    logic [N_CRN-1:0][TERM_W-1:0]  r_term_d;
    logic [DSC_W-1:0]              r_dsc_p;
    logic [DSC_W-1:0]              r_dsc_d;
    // stage E: divider request
    logic                          r_v_e;
    t_div_req                      r_req;

    logic                          ld_c;
    logic                          ld_d;
    logic                          ld_e;
    logic [N_CRN-1:0][PROD_W-1:0]  n_prod;
    logic [N_CRN-1:0][LAB_W-1:0]   n_lab_p;
    logic [N_CRN-1:0][LAB_W-1:0]   n_lab_d;
    logic [N_CRN-1:0]              n_use;
    logic [N_CRN-1:0][TERM_W-1:0]  n_term_p;
    logic [N_CRN-1:0][TERM_W-1:0]  n_term_d;
    logic [BAND_W-1:0]             eb1;
    logic [BAND_W-1:0]             rb1;
    logic [SUM_W-1:0]              sum_p;
    logic [SUM_W-1:0]              sum_d;
    t_div_req                      n_req;

    assign ld_e       = !r_v_e || i_out_ready;
    assign ld_d       = !r_v_d || ld_e;
    assign ld_c       = !r_v_c || ld_d;
    assign o_in_ready = ld_c;

    // Corners: own cell, error neighbour, rate neighbour, diagonal
    always_comb begin
        eb1 = i_in_data.eb + BAND_W'(1);
        rb1 = i_in_data.rb + BAND_W'(1);
        n_prod[0] = PROD_W'(i_in_data.wr0) * PROD_W'(i_in_data.we0);
        n_prod[1] = PROD_W'(i_in_data.wr0) * PROD_W'(i_in_data.we1);
        n_prod[2] = PROD_W'(i_in_data.wr1) * PROD_W'(i_in_data.we0);
        n_prod[3] = PROD_W'(i_in_data.wr1) * PROD_W'(i_in_data.we1);
        n_lab_p[0] = rule_p(i_in_data.rb, i_in_data.eb);
        n_lab_p[1] = rule_p(i_in_data.rb, eb1);
        n_lab_p[2] = rule_p(rb1, i_in_data.eb);
        n_lab_p[3] = rule_p(rb1, eb1);
        n_lab_d[0] = rule_d(i_in_data.rb, i_in_data.eb);
        n_lab_d[1] = rule_d(i_in_data.rb, eb1);
        n_lab_d[2] = rule_d(rb1, i_in_data.eb);
        n_lab_d[3] = rule_d(rb1, eb1);
        // drop neighbours past the top edge
        n_use[0] = 1'b1;
        n_use[1] = (int'(i_in_data.eb) < LEVELS - 1) && (int'(i_in_data.rb) <= LEVELS - 1);
        n_use[2] = (int'(i_in_data.rb) < LEVELS - 1) && (int'(i_in_data.eb) <= LEVELS - 1);
        n_use[3] = (int'(i_in_data.eb) < LEVELS - 1) && (int'(i_in_data.rb) < LEVELS - 1);
    end

    // Labels at or above LEVELS contribute nothing
    always_comb begin
        for (int c = 0; c < N_CRN; c++) begin
            n_term_p[c] = '0;
            n_term_d[c] = '0;
            if (r_use[c] && int'(r_lab_p[c]) < LEVELS) begin
                n_term_p[c] = TERM_W'(r_prod[c]) * TERM_W'(centre_p(r_lab_p[c]));
            end
            if (r_use[c] && int'(r_lab_d[c]) < LEVELS) begin
                n_term_d[c] = TERM_W'(r_prod[c]) * TERM_W'(centre_d(r_lab_d[c]));
            end
        end
    end

    // numerator = 8192 * sum + scaled den, divisor = 2 * scaled den: round half up
    always_comb begin
        sum_p = SUM_W'(r_term_p[0]) + SUM_W'(r_term_p[1])
              + SUM_W'(r_term_p[2]) + SUM_W'(r_term_p[3]);
        sum_d = SUM_W'(r_term_d[0]) + SUM_W'(r_term_d[1])
              + SUM_W'(r_term_d[2]) + SUM_W'(r_term_d[3]);
        n_req.num[LANE_P] = (NUM_W'(sum_p) << FRAC_SH) + NUM_W'(r_dsc_p);
        n_req.num[LANE_D] = (NUM_W'(sum_d) << FRAC_SH) + NUM_W'(r_dsc_d);
        n_req.dv[LANE_P]  = {r_dsc_p, 1'b0};
        n_req.dv[LANE_D]  = {r_dsc_d, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
        end else begin
            if (ld_c) r_v_c <= i_in_valid;
            if (ld_d) r_v_d <= r_v_c;
            if (ld_e) r_v_e <= r_v_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_c && i_in_valid) begin
            r_prod  <= n_prod;
            r_lab_p <= n_lab_p;
            r_lab_d <= n_lab_d;
            r_use   <= n_use;
            r_den   <= DEN_W'(i_in_data.de) * DEN_W'(i_in_data.dr);
        end
        if (ld_d && r_v_c) begin
            r_term_p <= n_term_p;
            r_term_d <= n_term_d;
            r_dsc_p  <= DSC_W'(r_den) * DSC_W'(P_SCALE);
            r_dsc_d  <= DSC_W'(r_den) * DSC_W'(D_SCALE);
        end
        if (ld_e && r_v_d) begin
            r_req <= n_req;
        end
    end

    assign o_out_valid = r_v_e;
    assign o_out_data  = r_req;

endmodule

`default_nettype wire

[hw/rtl/fpg_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes (P, D).
// The last stage is the output register; uses fpg_pkg.
`default_nettype none

module fpg_div import fpg_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_div_req i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out          o_out_data
);

    // partial remainder above, numerator bits turning into quotient below
    localparam int ACC_W = DIV_W + Q_W;

    logic [N_LANE-1:0][ACC_W-1:0] r_acc [Q_W];
    logic [N_LANE-1:0][DIV_W-1:0] r_dv  [Q_W];
    logic [Q_W-1:0]               r_v;

    logic [N_LANE-1:0][ACC_W-1:0] w_src    [Q_W];
    logic [N_LANE-1:0][DIV_W-1:0] w_dv_src [Q_W];
    logic [N_LANE-1:0][ACC_W-1:0] n_acc    [Q_W];
    logic [Q_W-1:0]               w_v_src;
    logic [Q_W:0]                 ld;

    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] a,
                                                  input logic [DIV_W-1:0] dv);
        logic [DIV_W:0] t;
        logic           ge;
        logic [DIV_W:0] rem;
        t   = {a[ACC_W-1:Q_W], a[Q_W-1]};
        ge  = t >= {1'b0, dv};
        rem = ge ? t - {1'b0, dv} : t;
        return {rem[DIV_W-1:0], a[Q_W-2:0], ge};
    endfunction

    // Hold a stage while it is full and the next one cannot take it
    always_comb begin
        ld[Q_W] = i_out_ready;
        for (int k = Q_W - 1; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end
    assign o_in_ready = ld[0];

    // The quotient fits in Q_W bits, so the upper numerator bits start below dv
    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            w_src[0][l] = {DIV_W'(i_in_data.num[l][NUM_W-1:Q_W]),
                           i_in_data.num[l][Q_W-1:0]};
        end
        w_dv_src[0] = i_in_data.dv;
        w_v_src[0]  = i_in_valid;
        for (int k = 1; k < Q_W; k++) begin
            w_src[k]    = r_acc[k-1];
            w_dv_src[k] = r_dv[k-1];
            w_v_src[k]  = r_v[k-1];
        end
        for (int k = 0; k < Q_W; k++) begin
            for (int l = 0; l < N_LANE; l++) begin
                n_acc[k][l] = div_step(w_src[k][l], w_dv_src[k][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (ld[k]) r_v[k] <= w_v_src[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (ld[k] && w_v_src[k]) begin
                r_acc[k] <= n_acc[k];
                r_dv[k]  <= w_dv_src[k];
            end
        end
    end

    assign o_out_valid       = r_v[Q_W-1];
    assign o_out_data.gain_p = r_acc[Q_W-1][LANE_P][Q_W-1:0];
    assign o_out_data.gain_d = r_acc[Q_W-1][LANE_D][Q_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/fuzzy_pd_gain_scheduler.sv]
// Fuzzy P/D gain scheduler: error and error rate in, P and D gains (Q4.12) out.
// Top level; instantiates fpg_front, fpg_rules and fpg_div, uses fpg_pkg.
//
// Usage:
//   Request channel i_in_valid / o_in_ready carries i_in_data (error_value,
//   error_rate_value, 16-bit signed). Result channel o_out_valid / i_out_ready
//   carries o_out_data (gain_p, gain_d, unsigned Q4.12). One result per request,
//   in request order.
//   Pipeline: 21 register stages: 2 stages of magnitude and band search, 3 of
//   rule evaluation and weighted sums, 16 of the restoring divider that rounds
//   each gain (one quotient bit per stage, both gains in parallel lanes).
//   Throughput: one request per cycle, sustained while i_out_ready stays high.
//   Every stage carries its own valid bit. When the receiver stalls, a full
//   stage holds and empty stages ahead of it keep filling, so o_in_ready drops
//   only once the whole pipeline is full; nothing is dropped or repeated.
//   Reset (synchronous, active low) empties the pipeline; the block keeps no
//   other state and needs no setup.
`default_nettype none

module fuzzy_pd_gain_scheduler import fpg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic      band_valid;
    logic      band_ready;
    t_band_req band_data;
    logic      div_valid;
    logic      div_ready;
    t_div_req  div_data;

    fpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (band_valid),
        .i_out_ready (band_ready),
        .o_out_data  (band_data)
    );

    fpg_rules u_rules (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (band_valid),
        .o_in_ready  (band_ready),
        .i_in_data   (band_data),
        .o_out_valid (div_valid),
        .i_out_ready (div_ready),
        .o_out_data  (div_data)
    );

    fpg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (div_valid),
        .o_in_ready  (div_ready),
        .i_in_data   (div_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
